// ===== src/ssw_pkg.sv =====
// ----------------------------------------------------------------------------
// ssw_pkg
// Shared types, constants and helpers for the sender sliding window tracker.
// ----------------------------------------------------------------------------
`default_nettype none

package ssw_pkg;

  localparam int WINDOW_DEPTH = 8;
  localparam int SEQ_BITS     = 32;

  localparam int CNT_W = $clog2(WINDOW_DEPTH + 1);
  localparam int PTR_W = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int SUM_W = CNT_W + 1;

  localparam int FUNC_W   = 2;
  localparam int STATUS_W = 3;
  localparam int HEAD_W   = 32;
  localparam int OCC_W    = 4;
  localparam int LIMIT_W  = 4;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 4'd8;

  typedef enum logic [FUNC_W-1:0] {
    FN_INSERT = 2'd0,
    FN_ACK    = 2'd1,
    FN_SLIDE  = 2'd2,
    FN_NOP    = 2'd3
  } func_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 3'd0,
    ST_FULL    = 3'd1,
    ST_RANGE   = 3'd2,
    ST_UNACKED = 3'd3,
    ST_EMPTY   = 3'd4
  } status_e;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [HEAD_W-1:0]   head_seqnum;
    logic [OCC_W-1:0]    occupancy;
    logic                head_acked;
  } res_t;

  // circular pointer advance, correct for offsets up to the depth
  function automatic logic [PTR_W-1:0] wrap_add(input logic [PTR_W-1:0] ptr,
                                                input logic [CNT_W-1:0] off);
    logic [SUM_W-1:0] s;
    s = SUM_W'(ptr) + SUM_W'(off);
    if (s >= SUM_W'(WINDOW_DEPTH)) begin
      s = s - SUM_W'(WINDOW_DEPTH);
    end
    return s[PTR_W-1:0];
  endfunction

endpackage

`default_nettype wire

// ===== src/sender_sliding_window_tracker.sv =====
// ----------------------------------------------------------------------------
// sender_sliding_window_tracker
// Sender-side selective-repeat window: insert, acknowledge and slide.
// ----------------------------------------------------------------------------
// Input channel (in_valid_i / in_stall_o) carries one operation per transfer:
// func_i selects insert, acknowledge, slide or no-op, seqnum_i the sequence
// number. Each transfer gives exactly one result on the output channel
// (out_valid_o / out_stall_i): status, head sequence number, occupancy and
// the head acked mark, all as they stand after the operation.
// Sequence numbers sit in a single-port circular store; acked marks and the
// head and tail copies are flip-flops.
// Insert, acknowledge, no-op and failed slide results are registered in the
// output stage from the cycle of the transfer. A successful slide reads the
// new head from the store, so its result passes through the store read and
// the fetch state before it is registered, and the input channel is stalled there.
// The config channel (cfg_valid_i / cfg_ready_o / cfg_data_i) writes the
// window limit; 0 acts as 1 and values above the depth act as the depth.
// Reset empties the window and sets the limit to 8. A stalled receiver
// holds the current result; one more result goes to a skid stage, after
// which the input channel stalls until the receiver takes a transfer.
// ----------------------------------------------------------------------------
`default_nettype none

module sender_sliding_window_tracker (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           in_valid_i,
  output logic                                in_stall_o,
  input  wire logic [ssw_pkg::FUNC_W-1:0]     func_i,
  input  wire logic [31:0]                    seqnum_i,
  output logic                                out_valid_o,
  input  wire logic                           out_stall_i,
  output logic [ssw_pkg::STATUS_W-1:0]        status_o,
  output logic [ssw_pkg::HEAD_W-1:0]          head_seqnum_o,
  output logic [ssw_pkg::OCC_W-1:0]           occupancy_o,
  output logic                                head_acked_o,
  input  wire logic                           cfg_valid_i,
  output logic                                cfg_ready_o,
  input  wire logic [ssw_pkg::LIMIT_W-1:0]    cfg_data_i
);
  import ssw_pkg::*;

  typedef enum logic {
    S_IDLE,
    S_FETCH
  } state_e;

  state_e                  state_q, state_d;
  logic [LIMIT_W-1:0]      limit_q;
  logic [CNT_W-1:0]        count_q, count_d;
  logic [PTR_W-1:0]        head_ptr_q, head_ptr_d;
  logic [WINDOW_DEPTH-1:0] acked_q, acked_d;
  logic [SEQ_BITS-1:0]     head_seq_q, head_seq_d;
  logic [SEQ_BITS-1:0]     tail_seq_q, tail_seq_d;

  logic [SEQ_BITS-1:0]     entry_seq_q [WINDOW_DEPTH];
  logic [SEQ_BITS-1:0]     rd_data_q;
  logic                    wr_en, rd_en;
  logic [PTR_W-1:0]        wr_addr, rd_addr;

  logic                    accept;
  logic                    skid_full;
  logic                    push;
  res_t                    res, res_out;
  logic [CNT_W-1:0]        lim;
  logic [SEQ_BITS-1:0]     seq_in;
  logic [SEQ_BITS-1:0]     ack_idx;
  logic [PTR_W-1:0]        tail_ptr;
  logic [PTR_W-1:0]        ack_ptr;
  logic                    ack_in_range;

  assign accept      = in_valid_i && !in_stall_o;
  assign in_stall_o  = (state_q != S_IDLE) || skid_full;
  assign cfg_ready_o = 1'b1;
  assign seq_in      = SEQ_BITS'(seqnum_i);

  always_comb begin
    if (limit_q == '0) begin
      lim = CNT_W'(1);
    end else if (int'(limit_q) > WINDOW_DEPTH) begin
      lim = CNT_W'(WINDOW_DEPTH);
    end else begin
      lim = CNT_W'(limit_q);
    end
  end

  assign tail_ptr     = wrap_add(head_ptr_q, count_q);
  assign ack_idx      = seq_in - head_seq_q;
  assign ack_ptr      = wrap_add(head_ptr_q, CNT_W'(ack_idx));
  assign ack_in_range = (seq_in >= head_seq_q) && (seq_in <= tail_seq_q) &&
                        (ack_idx < SEQ_BITS'(count_q));

  always_comb begin
    state_d    = state_q;
    count_d    = count_q;
    head_ptr_d = head_ptr_q;
    acked_d    = acked_q;
    head_seq_d = head_seq_q;
    tail_seq_d = tail_seq_q;
    wr_en      = 1'b0;
    wr_addr    = tail_ptr;
    rd_en      = 1'b0;
    rd_addr    = head_ptr_q;
    push       = 1'b0;
    res.status      = ST_OK;
    res.head_seqnum = (count_q != '0) ? HEAD_W'(head_seq_q) : '0;
    res.occupancy   = OCC_W'(count_q);
    res.head_acked  = (count_q != '0) && acked_q[head_ptr_q];
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          push = 1'b1;
          case (func_e'(func_i))
            FN_INSERT: begin
              if (count_q >= lim) begin
                res.status = ST_FULL;
              end else begin
                wr_en             = 1'b1;
                acked_d[tail_ptr] = 1'b0;
                count_d           = count_q + CNT_W'(1);
                tail_seq_d        = seq_in;
                res.occupancy     = OCC_W'(count_d);
                if (count_q == '0) begin
                  head_seq_d      = seq_in;
                  res.head_seqnum = HEAD_W'(seq_in);
                  res.head_acked  = 1'b0;
                end
              end
            end
            FN_ACK: begin
              if (count_q == '0) begin
                res.status = ST_EMPTY;
              end else if (!ack_in_range) begin
                res.status = ST_RANGE;
              end else begin
                acked_d[ack_ptr] = 1'b1;
                res.head_acked   = acked_d[head_ptr_q];
              end
            end
            FN_SLIDE: begin
              if (count_q == '0) begin
                res.status = ST_EMPTY;
              end else if (!acked_q[head_ptr_q]) begin
                res.status = ST_UNACKED;
              end else begin
                push                = 1'b0;
                acked_d[head_ptr_q] = 1'b0;
                head_ptr_d          = wrap_add(head_ptr_q, CNT_W'(1));
                count_d             = count_q - CNT_W'(1);
                rd_en               = 1'b1;
                rd_addr             = head_ptr_d;
                state_d             = S_FETCH;
              end
            end
            default: begin
              res.status = ST_OK;
            end
          endcase
        end
      end
      S_FETCH: begin
        push            = 1'b1;
        head_seq_d      = rd_data_q;
        res.head_seqnum = (count_q != '0) ? HEAD_W'(rd_data_q) : '0;
        state_d         = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      limit_q    <= LIMIT_RESET;
      count_q    <= '0;
      head_ptr_q <= '0;
      acked_q    <= '0;
    end else begin
      state_q    <= state_d;
      count_q    <= count_d;
      head_ptr_q <= head_ptr_d;
      acked_q    <= acked_d;
      if (cfg_valid_i && cfg_ready_o) begin
        limit_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    head_seq_q <= head_seq_d;
    tail_seq_q <= tail_seq_d;
  end

  // sequence number store
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      entry_seq_q[wr_addr] <= seq_in;
    end
    if (rd_en) begin
      rd_data_q <= entry_seq_q[rd_addr];
    end
  end

  ssw_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .res_i       (res),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .res_o       (res_out),
    .full_o      (skid_full)
  );

  assign status_o      = res_out.status;
  assign head_seqnum_o = res_out.head_seqnum;
  assign occupancy_o   = res_out.occupancy;
  assign head_acked_o  = res_out.head_acked;

endmodule

`default_nettype wire

// ===== src/ssw_out_buf.sv =====
// ----------------------------------------------------------------------------
// ssw_out_buf
// Result register with a skid stage so the tracker can take one more transfer
// while a finished result waits on a stalled receiver.
// ----------------------------------------------------------------------------
`default_nettype none

module ssw_out_buf (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_i,
  input  wire ssw_pkg::res_t res_i,
  input  wire logic          out_stall_i,
  output logic               out_valid_o,
  output ssw_pkg::res_t      res_o,
  output logic               full_o
);
  import ssw_pkg::*;

  logic out_valid_q;
  logic skid_valid_q;
  res_t out_q;
  res_t skid_q;
  logic pop;

  assign pop = out_valid_q && !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      if (skid_valid_q) begin
        if (pop) begin
          out_valid_q  <= 1'b1;
          skid_valid_q <= 1'b0;
        end
      end else if (push_i) begin
        if (!out_valid_q || pop) begin
          out_valid_q <= 1'b1;
        end else begin
          skid_valid_q <= 1'b1;
        end
      end else if (pop) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (pop) begin
        out_q <= skid_q;
      end
    end else if (push_i) begin
      if (!out_valid_q || pop) begin
        out_q <= res_i;
      end else begin
        skid_q <= res_i;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign res_o       = out_q;
  assign full_o      = skid_valid_q;

endmodule

`default_nettype wire

// ===== src/ssw_checker.sv =====
// ----------------------------------------------------------------------------
// ssw_checker
// Port-level checks for the sender sliding window tracker, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

module ssw_checker (
  input wire logic                        clk_i,
  input wire logic                        rst_ni,
  input wire logic                        out_valid_o,
  input wire logic                        out_stall_i,
  input wire logic [ssw_pkg::STATUS_W-1:0] status_o,
  input wire logic [ssw_pkg::HEAD_W-1:0]   head_seqnum_o,
  input wire logic [ssw_pkg::OCC_W-1:0]    occupancy_o,
  input wire logic                        head_acked_o
);
  import ssw_pkg::*;

  // empty window reports a cleared head
  a_empty_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (occupancy_o == '0) |-> (head_seqnum_o == '0) && !head_acked_o)
    else $error("empty window with non-zero head");

  a_empty_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == ST_EMPTY) |-> (occupancy_o == '0))
    else $error("empty status with entries outstanding");

  a_unacked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == ST_UNACKED) |-> (occupancy_o != '0) && !head_acked_o)
    else $error("unacked status inconsistent with head");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(status_o) &&
      $stable(head_seqnum_o) && $stable(occupancy_o) && $stable(head_acked_o))
    else $error("stalled result changed");

endmodule

bind sender_sliding_window_tracker ssw_checker u_ssw_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid_o   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .status_o      (status_o),
  .head_seqnum_o (head_seqnum_o),
  .occupancy_o   (occupancy_o),
  .head_acked_o  (head_acked_o)
);

`default_nettype wire

// ===== tb/sv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the sender sliding window tracker.
// ----------------------------------------------------------------------------
// A shadow copy of the window (sequence numbers, acked marks, fill count and
// limit) predicts status, head, occupancy and head mark for every accepted
// operation. Results are compared in order as they leave the output channel.
// A short directed run covers empty, full, out-of-range, repeated ack,
// unacked slide, no-op and the sequence number extremes. Random phases then
// follow, one per window limit setting, with bursty input and a receiver
// that stalls on patterns of its own.
// ----------------------------------------------------------------------------
module tb_top;
  import ssw_pkg::*;

  localparam int HANG_LIMIT     = 4000;
  localparam int RAND_PER_PHASE = 62;

  class window_shadow;
    logic [31:0]        seq_store [WINDOW_DEPTH];
    bit                 acked [WINDOW_DEPTH];
    int unsigned        fill;
    logic [LIMIT_W-1:0] limit;
    res_t               pending_results [$];
    int                 errors;
    int                 status_seen [5];

    function new();
      limit  = LIMIT_RESET;
      fill   = 0;
      errors = 0;
      foreach (acked[i]) begin
        acked[i]     = 1'b0;
        seq_store[i] = '0;
      end
      foreach (status_seen[i]) status_seen[i] = 0;
    endfunction

    function void note_op(func_e fn, logic [31:0] seq);
      int unsigned cap;
      logic [31:0] off;
      status_e     st;
      res_t        r;
      cap = (limit == 0) ? 1 : ((limit > WINDOW_DEPTH) ? WINDOW_DEPTH : limit);
      st  = ST_OK;
      case (fn)
        FN_INSERT: begin
          if (fill >= cap) begin
            st = ST_FULL;
          end else begin
            seq_store[fill] = seq;
            acked[fill]     = 1'b0;
            fill++;
          end
        end
        FN_ACK: begin
          if (fill == 0) begin
            st = ST_EMPTY;
          end else if (seq < seq_store[0] || seq > seq_store[fill-1]) begin
            st = ST_RANGE;
          end else begin
            off = seq - seq_store[0];
            if (off >= fill) st = ST_RANGE;
            else acked[off] = 1'b1;
          end
        end
        FN_SLIDE: begin
          if (fill == 0) begin
            st = ST_EMPTY;
          end else if (!acked[0]) begin
            st = ST_UNACKED;
          end else begin
            for (int i = 0; i + 1 < fill; i++) begin
              seq_store[i] = seq_store[i+1];
              acked[i]     = acked[i+1];
            end
            fill--;
            seq_store[fill] = '0;
            acked[fill]     = 1'b0;
          end
        end
        default: st = ST_OK;
      endcase
      r.status      = st;
      r.head_seqnum = (fill != 0) ? seq_store[0] : '0;
      r.occupancy   = OCC_W'(fill);
      r.head_acked  = (fill != 0) && acked[0];
      status_seen[int'(st)]++;
      pending_results.push_back(r);
    endfunction

    function void check_result(res_t got);
      res_t want;
      if (pending_results.size() == 0) begin
        $error("result with nothing outstanding: status %0d head %h occupancy %0d",
               got.status, got.head_seqnum, got.occupancy);
        errors++;
        return;
      end
      want = pending_results.pop_front();
      if (got.status !== want.status) begin
        $error("status: expected %0d, got %0d", want.status, got.status);
        errors++;
      end
      if (got.head_seqnum !== want.head_seqnum) begin
        $error("head_seqnum: expected %h, got %h", want.head_seqnum, got.head_seqnum);
        errors++;
      end
      if (got.occupancy !== want.occupancy) begin
        $error("occupancy: expected %0d, got %0d", want.occupancy, got.occupancy);
        errors++;
      end
      if (got.head_acked !== want.head_acked) begin
        $error("head_acked: expected %0d, got %0d", want.head_acked, got.head_acked);
        errors++;
      end
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [FUNC_W-1:0]    func_in = '0;
  logic [31:0]          seq_in = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [STATUS_W-1:0]  status;
  logic [HEAD_W-1:0]    head_seqnum;
  logic [OCC_W-1:0]     occupancy;
  logic                 head_acked;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [LIMIT_W-1:0]   cfg_data = '0;

  window_shadow sb;
  int           burst_left = 0;
  int           ops_sent = 0;
  int           results_seen = 0;
  int           limit_writes = 0;
  int           idle_cycles = 0;
  logic [31:0]  next_seq = 32'd1000;

  sender_sliding_window_tracker uut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_stall_o    (in_stall),
    .func_i        (func_in),
    .seqnum_i      (seq_in),
    .out_valid_o   (out_valid),
    .out_stall_i   (out_stall),
    .status_o      (status),
    .head_seqnum_o (head_seqnum),
    .occupancy_o   (occupancy),
    .head_acked_o  (head_acked),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_o   (cfg_ready),
    .cfg_data_i    (cfg_data)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // receiver stall pattern
  initial begin
    int pct;
    int len;
    forever begin
      case ($urandom_range(0, 4))
        0, 1:    pct = 0;
        2:       pct = 25;
        3:       pct = 60;
        default: pct = 90;
      endcase
      len = $urandom_range(16, 96);
      repeat (len) begin
        @(negedge clk);
        out_stall = ($urandom_range(0, 99) < pct);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (out_valid && !out_stall) begin
        sb.check_result(res_t'({status, head_seqnum, occupancy, head_acked}));
        results_seen++;
      end
      if (idle_cycles >= HANG_LIMIT) begin
        $display("FAIL sender_sliding_window_tracker");
        $finish;
      end
    end
  end

  task automatic send_op(input func_e fn, input logic [31:0] seq);
    @(negedge clk);
    in_valid = 1'b1;
    func_in  = fn;
    seq_in   = seq;
    do @(posedge clk); while (in_stall);
    sb.note_op(fn, seq);
    ops_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      @(negedge clk);
      in_valid = 1'b0;
      repeat ($urandom_range(0, 6)) @(negedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80) : $urandom_range(0, 12);
    end
  endtask

  task automatic drain_results();
    @(negedge clk);
    in_valid = 1'b0;
    while (sb.pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_limit(input logic [LIMIT_W-1:0] value);
    drain_results();
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_data  = value;
    do @(posedge clk); while (!cfg_ready);
    sb.limit = value;
    limit_writes++;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic run_directed();
    send_op(FN_SLIDE, 32'h0);
    send_op(FN_ACK, 32'h0);
    send_op(FN_NOP, 32'hFFFF_FFFF);
    send_op(FN_INSERT, 32'hFFFF_FFFE);
    send_op(FN_INSERT, 32'hFFFF_FFFF);
    send_op(FN_SLIDE, 32'h0);
    send_op(FN_ACK, 32'hFFFF_FFFF);
    send_op(FN_ACK, 32'hFFFF_FFFF);
    send_op(FN_ACK, 32'hFFFF_FFFD);
    send_op(FN_ACK, 32'h0);
    send_op(FN_ACK, 32'hFFFF_FFFE);
    send_op(FN_SLIDE, 32'hFFFF_FFFF);
    send_op(FN_SLIDE, 32'h0);
    // out-of-order inserts, ack inside the span but past the occupancy
    send_op(FN_INSERT, 32'd100);
    send_op(FN_INSERT, 32'd50);
    send_op(FN_INSERT, 32'd200);
    send_op(FN_ACK, 32'd150);
    send_op(FN_ACK, 32'd101);
    for (int i = 0; i < 5; i++) send_op(FN_INSERT, 32'(i));
    send_op(FN_INSERT, 32'h5555_AAAA);
  endtask

  task automatic run_random(input int count);
    int pick;
    if (sb.fill != 0) next_seq = sb.seq_store[sb.fill-1] + 1;
    for (int k = 0; k < count; k++) begin
      if (sb.fill == 0 && $urandom_range(0, 3) == 0)
        next_seq = $urandom_range(0, 1) ? $urandom : 32'hFFFF_FFFF - $urandom_range(0, 12);
      pick = $urandom_range(0, 99);
      if (pick < 34) begin
        if ($urandom_range(0, 19) == 0) begin
          send_op(FN_INSERT, $urandom);
        end else begin
          send_op(FN_INSERT, next_seq);
          next_seq++;
        end
      end else if (pick < 68) begin
        if (sb.fill != 0 && $urandom_range(0, 9) != 0)
          send_op(FN_ACK, sb.seq_store[0] + $urandom_range(0, sb.fill - 1));
        else if (sb.fill != 0 && $urandom_range(0, 1) == 0)
          send_op(FN_ACK, $urandom_range(0, 1) ? sb.seq_store[0] - 1 : sb.seq_store[0] + sb.fill);
        else
          send_op(FN_ACK, $urandom);
      end else if (pick < 94) begin
        send_op(FN_SLIDE, $urandom);
      end else begin
        send_op(FN_NOP, $urandom);
      end
    end
  endtask

  initial begin
    logic [LIMIT_W-1:0] limits [7];
    sb = new();
    limits = '{4'd1, 4'd0, 4'd15, 4'd3, 4'd8, LIMIT_W'($urandom_range(0, 15)), 4'd5};
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    run_directed();
    run_random(RAND_PER_PHASE);
    foreach (limits[i]) begin
      write_limit(limits[i]);
      run_random(RAND_PER_PHASE);
    end

    drain_results();
    repeat (4) @(posedge clk);

    $display("covered %0d operations and %0d results over %0d limit writes",
             ops_sent, results_seen, limit_writes);
    $display("status mix: ok %0d full %0d range %0d unacked %0d empty %0d",
             sb.status_seen[0], sb.status_seen[1], sb.status_seen[2],
             sb.status_seen[3], sb.status_seen[4]);
    if (sb.errors == 0 && sb.pending_results.size() == 0) begin
      $display("PASS sender_sliding_window_tracker");
    end else begin
      $display("FAIL sender_sliding_window_tracker");
    end
    $finish;
  end

endmodule
